[hw/rtl/lobm_pkg.sv]
//------------------------------------------------------------------------------
// lobm_pkg: shared types and constants for the order book matcher
// Sizes, result codes, controller states and the ctrl/datapath interface.
//------------------------------------------------------------------------------
`default_nettype none
package lobm_pkg;
  localparam int PRICE_LEVELS   = 256;
  localparam int ORDER_SLOTS    = 64;
  localparam int QUANTITY_WIDTH = 16;
  localparam int LVL_W  = $clog2(PRICE_LEVELS);
  localparam int SLOT_W = $clog2(ORDER_SLOTS);
  localparam int CNT_W  = $clog2(ORDER_SLOTS + 1);

  typedef logic [1:0] status_t;
  localparam status_t ST_TRADE   = 2'd0;
  localparam status_t ST_NOMATCH = 2'd1;
  localparam status_t ST_INVALID = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  localparam logic [1:0] SIDE_BUY  = 2'd0;
  localparam logic [1:0] SIDE_SELL = 2'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SCAN, S_HEAD, S_SLOT, S_TRADE, S_REST, S_LINK, S_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // latch the incoming order
    logic scan_start;  // restart the best-level scan
    logic scan_step;   // advance scan one level
    logic rd_head;     // read level head
    logic rd_slot;     // read slot entry
    logic trade;       // build trade, update book
    logic rest;        // allocate slot for remainder
    logic link;        // append slot to level list
    logic emit_single; // emit one single status item
    logic flush;       // scan decided: release a held trade
    logic flush_last;  // held trade is the order's final result
    status_t single_code;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic invalid;     // side is not buy or sell
    logic rem_zero;    // remainder is zero
    logic scan_done;   // scan finished
    logic scan_hit;    // best level found and crosses
    logic any_trade;   // at least one trade this order
    logic trade_cap;   // trade count hit the limit
    logic free_empty;  // no free slot
    logic lvl_occ;     // own level already occupied
    logic init_busy;   // free stack still filling after reset
  } stat_t;

  function automatic logic [QUANTITY_WIDTH-1:0] qmin(
      input logic [QUANTITY_WIDTH-1:0] a, input logic [QUANTITY_WIDTH-1:0] b);
    qmin = (a < b) ? a : b;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/lobm_ctrl.sv]
//------------------------------------------------------------------------------
// lobm_ctrl: sequencing FSM for the order book matcher
// Steps one order through check, level scan, trade loop and resting.
//------------------------------------------------------------------------------
`default_nettype none
module lobm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output lobm_pkg::ctrl_t     ctrl,
  input  wire lobm_pkg::stat_t stat
);
  import lobm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start && !stat.init_busy) state_nxt = S_CHECK;
      S_CHECK: begin
        if (stat.invalid || stat.rem_zero) state_nxt = S_DONE;
        else                               state_nxt = S_SCAN;
      end
      S_SCAN: begin
        priority if (stat.rem_zero)                    state_nxt = S_DONE;
        else if (stat.trade_cap)                       state_nxt = S_REST;
        else if (stat.scan_done && stat.scan_hit)      state_nxt = S_HEAD;
        else if (stat.scan_done)                       state_nxt = S_REST;
        else                                           state_nxt = S_SCAN;
      end
      S_HEAD:  state_nxt = S_SLOT;
      S_SLOT:  state_nxt = S_TRADE;
      S_TRADE: state_nxt = S_SCAN;
      S_REST:  begin
        if (stat.free_empty) state_nxt = S_DONE;
        else                 state_nxt = S_LINK;
      end
      S_LINK:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state_r != S_IDLE) || stat.init_busy;
    unique case (state_r)
      S_IDLE:  ctrl.load = start && !stat.init_busy;
      S_CHECK: begin
        ctrl.scan_start = 1'b1;
        if (stat.invalid) begin
          ctrl.emit_single = 1'b1;
          ctrl.single_code = ST_INVALID;
        end else if (stat.rem_zero) begin
          ctrl.emit_single = 1'b1;
          ctrl.single_code = ST_NOMATCH;
        end
      end
      S_SCAN:  begin
        ctrl.scan_step  = 1'b1;
        // once the scan decides, the held trade knows whether it is last
        ctrl.flush      = stat.rem_zero || stat.trade_cap || stat.scan_done;
        ctrl.flush_last = stat.rem_zero || stat.trade_cap || !stat.scan_hit;
      end
      S_HEAD:  ctrl.rd_head = 1'b1;
      S_SLOT:  ctrl.rd_slot = 1'b1;
      S_TRADE: ctrl.trade = 1'b1;
      S_REST:  begin
        ctrl.rest = !stat.free_empty;
        if (!stat.any_trade) begin
          ctrl.emit_single = 1'b1;
          ctrl.single_code = stat.free_empty ? ST_FULL : ST_NOMATCH;
        end
      end
      S_LINK:  ctrl.link = 1'b1;
      S_DONE:  ;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/lobm_dpath.sv]
//------------------------------------------------------------------------------
// lobm_dpath: book storage and matching datapath
// Level bitmaps, level/slot memories, free stack, result register.
//------------------------------------------------------------------------------
`default_nettype none
module lobm_dpath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic [1:0]                           in_side,
  input  wire logic [7:0]                           in_price,
  input  wire logic [15:0]                          in_quantity,
  input  wire lobm_pkg::ctrl_t                      ctrl,
  output lobm_pkg::stat_t                           stat,
  output logic                                      out_valid,
  output logic [1:0]                                out_status,
  output logic [31:0]                               out_incoming_id,
  output logic [31:0]                               out_buy_id,
  output logic [31:0]                               out_sell_id,
  output logic [7:0]                                out_trade_price,
  output logic [15:0]                               out_trade_qty,
  output logic                                      out_last
);
  import lobm_pkg::*;

  typedef logic [QUANTITY_WIDTH-1:0] qty_t;

  // order registers
  logic [31:0] next_id_r, id_r;
  logic [1:0]  side_r;
  logic [LVL_W-1:0] price_r;
  qty_t        rem_r;
  logic        invalid_r;

  // book state
  logic [PRICE_LEVELS-1:0] buy_occ_r, sell_occ_r;
  logic [SLOT_W-1:0] head_mem [2*PRICE_LEVELS];
  logic [SLOT_W-1:0] tail_mem [2*PRICE_LEVELS];
  logic [31:0]       sid_mem  [ORDER_SLOTS];
  qty_t              sqty_mem [ORDER_SLOTS];
  logic [SLOT_W-1:0] snext_mem[ORDER_SLOTS];
  logic [SLOT_W-1:0] free_mem [ORDER_SLOTS];
  logic [CNT_W-1:0]  free_cnt_r;
  logic [CNT_W-1:0]  init_r;   // fill pass index for free stack

  // scan
  logic [LVL_W-1:0] scan_lvl_r;
  logic             scan_done_r;
  logic [CNT_W-1:0] ntrade_r;
  logic             pend_r;    // trade held in the result regs, not yet out

  // read registers
  logic [SLOT_W-1:0] head_q, tail_q, slot_h_r;
  logic [31:0]       sid_q;
  qty_t              sqty_q;
  logic [SLOT_W-1:0] snext_q;
  logic [SLOT_W-1:0] free_q;
  logic [SLOT_W-1:0] tail_own_q;
  logic              lvl_was_occ_r;

  logic [LVL_W:0]    key_opp, key_own;
  logic              opp_buy;
  logic              cur_occ, crosses, last_lvl;
  qty_t              tq;

  assign opp_buy = (side_r == SIDE_SELL);
  assign key_opp = {opp_buy ? 1'b0 : 1'b1, scan_lvl_r};
  assign key_own = {side_r[0], price_r};
  assign cur_occ = opp_buy ? buy_occ_r[scan_lvl_r] : sell_occ_r[scan_lvl_r];
  assign crosses = opp_buy ? (scan_lvl_r >= price_r) : (scan_lvl_r <= price_r);
  assign last_lvl = opp_buy ? (scan_lvl_r == '0)
                            : (scan_lvl_r == LVL_W'(PRICE_LEVELS - 1));
  assign tq = qmin(sqty_q, rem_r);

  always_comb begin
    stat.invalid    = invalid_r;
    stat.rem_zero   = (rem_r == '0);
    stat.scan_done  = scan_done_r || (cur_occ && crosses) || !crosses || last_lvl;
    stat.scan_hit   = !scan_done_r && cur_occ && crosses;
    stat.any_trade  = (ntrade_r != '0);
    stat.trade_cap  = (ntrade_r == CNT_W'(ORDER_SLOTS));
    stat.free_empty = (free_cnt_r == '0);
    stat.lvl_occ    = side_r[0] ? sell_occ_r[price_r] : buy_occ_r[price_r];
    stat.init_busy  = (init_r != CNT_W'(ORDER_SLOTS));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r   <= 32'd1;
      buy_occ_r   <= '0;
      sell_occ_r  <= '0;
      free_cnt_r  <= CNT_W'(ORDER_SLOTS);
      init_r      <= '0;
      scan_done_r <= 1'b0;
      ntrade_r    <= '0;
      pend_r      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= ctrl.emit_single || (ctrl.flush && pend_r);
      if (init_r != CNT_W'(ORDER_SLOTS)) init_r <= init_r + 1'b1;
      if (ctrl.load) begin
        next_id_r <= next_id_r + 32'd1;
        ntrade_r  <= '0;
        pend_r    <= 1'b0;
      end
      if (ctrl.scan_start) scan_done_r <= 1'b0;
      if (ctrl.scan_step && !scan_done_r)
        scan_done_r <= (cur_occ && crosses) || !crosses || last_lvl;
      if (ctrl.flush && pend_r) pend_r <= 1'b0;
      if (ctrl.trade) begin
        pend_r    <= 1'b1;
        ntrade_r  <= ntrade_r + 1'b1;
        scan_done_r <= 1'b0;
        if (sqty_q == tq) begin
          if (head_q == tail_q) begin
            if (opp_buy) buy_occ_r[scan_lvl_r]  <= 1'b0;
            else         sell_occ_r[scan_lvl_r] <= 1'b0;
          end
          if (free_cnt_r != CNT_W'(ORDER_SLOTS)) free_cnt_r <= free_cnt_r + 1'b1;
        end
      end
      if (ctrl.rest) begin
        free_cnt_r <= free_cnt_r - 1'b1;
        if (side_r[0]) sell_occ_r[price_r] <= 1'b1;
        else           buy_occ_r[price_r]  <= 1'b1;
      end
    end
  end

  // payload registers and memories
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id_r      <= next_id_r;
      side_r    <= in_side;
      invalid_r <= in_side[1];
      price_r   <= in_price[LVL_W-1:0];
      rem_r     <= in_quantity[QUANTITY_WIDTH-1:0];
    end
    if (init_r != CNT_W'(ORDER_SLOTS))
      free_mem[init_r[SLOT_W-1:0]] <= init_r[SLOT_W-1:0];
    if (ctrl.scan_start) scan_lvl_r <= opp_buy ? LVL_W'(PRICE_LEVELS - 1) : '0;
    if (ctrl.scan_step && !stat.scan_done)
      scan_lvl_r <= opp_buy ? scan_lvl_r - 1'b1 : scan_lvl_r + 1'b1;
    if (ctrl.rd_head) begin
      head_q <= head_mem[key_opp];
      tail_q <= tail_mem[key_opp];
    end
    if (ctrl.rd_slot) begin
      sid_q    <= sid_mem[head_q];
      sqty_q   <= sqty_mem[head_q];
      snext_q  <= snext_mem[head_q];
      slot_h_r <= head_q;
    end
    if (ctrl.emit_single) begin
      out_status      <= ctrl.single_code;
      out_incoming_id <= id_r;
      out_buy_id      <= '0;
      out_sell_id     <= '0;
      out_trade_price <= '0;
      out_trade_qty   <= '0;
      out_last        <= 1'b1;
    end
    // held trade goes out once the scan knows if another follows
    if (ctrl.flush && pend_r) out_last <= ctrl.flush_last;
    if (ctrl.trade) begin
      out_status      <= ST_TRADE;
      out_incoming_id <= id_r;
      out_buy_id      <= opp_buy ? sid_q : id_r;
      out_sell_id     <= opp_buy ? id_r : sid_q;
      out_trade_price <= 8'(opp_buy ? price_r : scan_lvl_r);
      out_trade_qty   <= 16'(tq);
      rem_r           <= rem_r - tq;
      sqty_mem[slot_h_r] <= sqty_q - tq;
      if (sqty_q == tq) begin
        if (head_q != tail_q) head_mem[key_opp] <= snext_q;
        if (free_cnt_r != CNT_W'(ORDER_SLOTS))
          free_mem[free_cnt_r[SLOT_W-1:0]] <= slot_h_r;
      end
    end
    if (ctrl.rest) begin
      free_q     <= free_mem[free_cnt_r[SLOT_W-1:0] - 1'b1];
      tail_own_q <= tail_mem[key_own];
    end
    if (ctrl.link) begin
      sid_mem[free_q]   <= id_r;
      sqty_mem[free_q]  <= rem_r;
      snext_mem[free_q] <= '0;
      tail_mem[key_own] <= free_q;
      if (lvl_was_occ_r) snext_mem[tail_own_q] <= free_q;
      else               head_mem[key_own] <= free_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rest) lvl_was_occ_r <= stat.lvl_occ;
  end
endmodule
`default_nettype wire

[hw/rtl/limit_order_book_matcher_core.sv]
//------------------------------------------------------------------------------
// limit_order_book_matcher_core: price-time priority order matcher
// Invalid/zero orders pass check then done; each trade takes a scan decision,
// head read, slot read and update, with the scan stepping through price levels;
// resting adds slot allocation and linking. One order at a time: throughput is
// set by the linear best-level scan and the slot read loop. A trade is released
// at the next scan decision, so last is exact. Results cannot be stalled:
// out_valid is one cycle. Reset (rst_n low, sync) empties the book and sets the
// id counter to 1; busy stays high after reset while the free-slot stack fills.
//------------------------------------------------------------------------------
`default_nettype none
module limit_order_book_matcher_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_side,
  input  wire logic [7:0]  in_price,
  input  wire logic [15:0] in_quantity,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_incoming_id,
  output logic [31:0]      out_buy_id,
  output logic [31:0]      out_sell_id,
  output logic [7:0]       out_trade_price,
  output logic [15:0]      out_trade_qty,
  output logic             out_last
);
  import lobm_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // sequencer: one transfer in, then a run of result transfers
  lobm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .ctrl(ctrl), .stat(stat)
  );

  // book memories and matching arithmetic
  lobm_dpath u_dpath (
    .clk(clk), .rst_n(rst_n),
    .in_side(in_side), .in_price(in_price), .in_quantity(in_quantity),
    .ctrl(ctrl), .stat(stat),
    .out_valid(out_valid), .out_status(out_status),
    .out_incoming_id(out_incoming_id), .out_buy_id(out_buy_id),
    .out_sell_id(out_sell_id), .out_trade_price(out_trade_price),
    .out_trade_qty(out_trade_qty), .out_last(out_last)
  );

  // a result only appears while an order is in flight
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without order");

  // single status items always close the order
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_TRADE) |-> out_last)
    else $error("status item not last");

  // never two datapath writes of different kinds at once
  a_ctrl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.trade, ctrl.rest, ctrl.link})) else $error("ctrl overlap");
endmodule
`default_nettype wire
